// File: hdl/qte_pkg.sv
// Shared widths, angle constants and the CORDIC arctangent table.
`timescale 1ns / 1ps
`default_nettype none
package qte_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam int QW = 16;  // quaternion component, Q1.14
  localparam int PW = 32;  // component product
  localparam int SW = 36;  // sine / cosine terms, Q2.28
  localparam int VW = 57;  // square root radicand
  localparam int RW = 58;  // square root partial result
  localparam int CW = 38;  // CORDIC x / y
  localparam int ZW = 35;  // CORDIC angle, Q2.30
  localparam int OW = 18;  // rounded angle before clamping
  localparam int AW = 16;  // roll / yaw output
  localparam int HW = 15;  // pitch output

  // radicand at most 2^56, below 2^57: the first restoring step tests the 2^56 bit
  localparam int SQ_STEPS = 29;

  localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [OW-1:0] PI_Q13      = 18'sd25736;
  localparam logic signed [OW-1:0] HALF_PI_Q13 = 18'sd12868;
  localparam logic signed [SW-1:0] ONE_Q28     = 36'sd268435456;

  // atan(2^-i) in Q2.30
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 35'sd843314856;
      1:  a = 35'sd497837829;
      2:  a = 35'sd263043836;
      3:  a = 35'sd133525158;
      4:  a = 35'sd67021686;
      5:  a = 35'sd33543515;
      6:  a = 35'sd16775850;
      7:  a = 35'sd8388437;
      8:  a = 35'sd4194282;
      9:  a = 35'sd2097149;
      10: a = 35'sd1048575;
      11: a = 35'sd524287;
      12: a = 35'sd262143;
      13: a = 35'sd131071;
      14: a = 35'sd65535;
      15: a = 35'sd32767;
      16: a = 35'sd16383;
      17: a = 35'sd8191;
      18: a = 35'sd4095;
      19: a = 35'sd2047;
      20: a = 35'sd1023;
      21: a = 35'sd511;
      22: a = 35'sd255;
      23: a = 35'sd127;
      24: a = 35'sd63;
      25: a = 35'sd31;
      26: a = 35'sd15;
      27: a = 35'sd8;
      28: a = 35'sd4;
      29: a = 35'sd2;
      30: a = 35'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// File: hdl/qte_sqrt_cell.sv
// One restoring square root step, registered.
`timescale 1ns / 1ps
`default_nettype none
module qte_sqrt_cell import qte_pkg::*; #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [VW-1:0] v_in,
  input  wire logic [RW-1:0] res_in,
  output logic      [VW-1:0] v_out,
  output logic      [RW-1:0] res_out
);

  localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQ_STEPS - 1 - STEP));

  logic [RW-1:0] trial;
  logic [RW-1:0] v_ext;
  logic [RW-1:0] diff;

  assign trial = res_in + BIT;
  assign v_ext = {1'b0, v_in};
  assign diff  = v_ext - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      if (v_ext >= trial) begin
        v_out   <= diff[VW-1:0];
        res_out <= (res_in >> 1) + BIT;
      end else begin
        v_out   <= v_in;
        res_out <= res_in >> 1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered.
`timescale 1ns / 1ps
`default_nettype none
module qte_cordic_cell import qte_pkg::*; #(
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] x_in,
  input  wire logic signed [CW-1:0] y_in,
  input  wire logic signed [ZW-1:0] z_in,
  output logic      signed [CW-1:0] x_out,
  output logic      signed [CW-1:0] y_out,
  output logic      signed [ZW-1:0] z_out
);

  localparam logic signed [ZW-1:0] ANG = atan_q30(IDX);

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in > 0) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ANG;
      end else if (y_in < 0) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ANG;
      end else begin
        // y exactly zero: angle already settled
        x_out <= x_in;
        y_out <= y_in;
        z_out <= z_in;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/quaternion_to_euler_angles_unit.sv
// Top level: quaternion to roll / pitch / yaw, pipelined with CORDIC cells.
//
//   channel | signals                              | dir | beat
//   --------+--------------------------------------+-----+---------------------------
//   input   | in_valid, in_ready, quat_x/y/z/w     | in  | one quaternion, Q1.14
//   output  | out_valid, out_ready, roll/pitch/yaw | out | roll/yaw Q2.13, pitch Q1.13
//
// One beat enters per cycle while the pipe is not held. A beat passes
// 35 + CORDIC_STAGES registers (products, sums, square, radicand, 29 square root
// cells, pre-rotation, CORDIC cells, rounding) on its way to the output.
// The whole pipe moves on one enable: it holds only while the output register
// is full and out_ready is low, and bubbles travel down the pipe with the beats.
// Reset clears the valid line; the data path carries no reset.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler_angles_unit import qte_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [QW-1:0] quat_x,
  input  wire logic signed [QW-1:0] quat_y,
  input  wire logic signed [QW-1:0] quat_z,
  input  wire logic signed [QW-1:0] quat_w,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      signed [AW-1:0] roll_angle,
  output logic      signed [HW-1:0] pitch_angle,
  output logic      signed [AW-1:0] yaw_angle
);

  localparam int N = CORDIC_STAGES;
  localparam int L = 4 + SQ_STEPS + 1 + N + 1;  // pipeline depth
  localparam int LANES = 3;                      // roll, pitch, yaw
  localparam int LROLL = 0;
  localparam int LPITCH = 1;
  localparam int LYAW = 2;

  logic         en;
  logic [L-1:0] vld;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // ---------------- stage 1: products on the remapped axes
  // tx = z, ty = x, tz = y
  logic signed [PW-1:0] p_wtx, p_tytz, p_txtx, p_tyty, p_wty, p_tztx, p_wtz, p_txty, p_tztz;

  always_ff @(posedge clk) begin
    if (en) begin
      p_wtx  <= quat_w * quat_z;
      p_tytz <= quat_x * quat_y;
      p_txtx <= quat_z * quat_z;
      p_tyty <= quat_x * quat_x;
      p_wty  <= quat_w * quat_x;
      p_tztx <= quat_y * quat_z;
      p_wtz  <= quat_w * quat_y;
      p_txty <= quat_z * quat_x;
      p_tztz <= quat_y * quat_y;
    end
  end

  // ---------------- stage 2: sine and cosine terms, Q2.28
  logic signed [SW-1:0] sr2, cr2, sp2, sy2, cy2;

  always_ff @(posedge clk) begin
    if (en) begin
      sr2 <= (SW'(p_wtx) + SW'(p_tytz)) <<< 1;
      cr2 <= ONE_Q28 - ((SW'(p_txtx) + SW'(p_tyty)) <<< 1);
      sp2 <= (SW'(p_wty) - SW'(p_tztx)) <<< 1;
      sy2 <= (SW'(p_wtz) + SW'(p_txty)) <<< 1;
      cy2 <= ONE_Q28 - ((SW'(p_tyty) + SW'(p_tztz)) <<< 1);
    end
  end

  // ---------------- stage 3: pitch saturation test and s^2
  logic signed [SW-1:0] sr3, cr3, sp3, sy3, cy3;
  logic                 sat3, neg3;
  logic [55:0]          asq3;
  logic signed [SW-1:0] sp_abs;
  logic                 sat_c;
  logic [27:0]          a28;

  always_comb begin
    sp_abs = sp2[SW-1] ? -sp2 : sp2;
    sat_c  = (sp2 >= ONE_Q28) || (sp2 <= -ONE_Q28);
    a28    = sat_c ? '0 : sp_abs[27:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr3  <= sr2;
      cr3  <= cr2;
      sp3  <= sp2;
      sy3  <= sy2;
      cy3  <= cy2;
      sat3 <= sat_c;
      neg3 <= sp2[SW-1];
      asq3 <= a28 * a28;
    end
  end

  // ---------------- stage 4 and square root chain: c = sqrt(2^56 - s^2)
  logic signed [SW-1:0] sb_sr [0:SQ_STEPS];
  logic signed [SW-1:0] sb_cr [0:SQ_STEPS];
  logic signed [SW-1:0] sb_sp [0:SQ_STEPS];
  logic signed [SW-1:0] sb_sy [0:SQ_STEPS];
  logic signed [SW-1:0] sb_cy [0:SQ_STEPS];
  logic                 sb_sat [0:SQ_STEPS];
  logic                 sb_neg [0:SQ_STEPS];
  logic [VW-1:0]        sq_v [0:SQ_STEPS];
  logic [RW-1:0]        sq_r [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_sr[0]  <= sr3;
      sb_cr[0]  <= cr3;
      sb_sp[0]  <= sp3;
      sb_sy[0]  <= sy3;
      sb_cy[0]  <= cy3;
      sb_sat[0] <= sat3;
      sb_neg[0] <= neg3;
      sq_v[0]   <= (VW'(1) << 56) - VW'(asq3);
      sq_r[0]   <= '0;
      for (int j = 0; j < SQ_STEPS; j++) begin
        sb_sr[j+1]  <= sb_sr[j];
        sb_cr[j+1]  <= sb_cr[j];
        sb_sp[j+1]  <= sb_sp[j];
        sb_sy[j+1]  <= sb_sy[j];
        sb_cy[j+1]  <= sb_cy[j];
        sb_sat[j+1] <= sb_sat[j];
        sb_neg[j+1] <= sb_neg[j];
      end
    end
  end

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    qte_sqrt_cell #(.STEP(j)) u_cell (
      .clk     (clk),
      .en      (en),
      .v_in    (sq_v[j]),
      .res_in  (sq_r[j]),
      .v_out   (sq_v[j+1]),
      .res_out (sq_r[j+1])
    );
  end

  // ---------------- pre-rotation: turn a negative-x operand by pi
  logic signed [CW-1:0] px [LANES];
  logic signed [CW-1:0] py [LANES];
  logic signed [CW-1:0] cx [LANES][0:N];
  logic signed [CW-1:0] cy [LANES][0:N];
  logic signed [ZW-1:0] cz [LANES][0:N];
  logic                 cs_sat [0:N];
  logic                 cs_neg [0:N];

  always_comb begin
    px[LROLL]  = CW'(sb_cr[SQ_STEPS]);
    py[LROLL]  = CW'(sb_sr[SQ_STEPS]);
    px[LPITCH] = CW'($signed({1'b0, sq_r[SQ_STEPS][28:0]}));
    py[LPITCH] = CW'(sb_sp[SQ_STEPS]);
    px[LYAW]   = CW'(sb_cy[SQ_STEPS]);
    py[LYAW]   = CW'(sb_sy[SQ_STEPS]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_sat[0] <= sb_sat[SQ_STEPS];
      cs_neg[0] <= sb_neg[SQ_STEPS];
      for (int l = 0; l < LANES; l++) begin
        if (px[l] < 0) begin
          cx[l][0] <= -px[l];
          cy[l][0] <= -py[l];
          cz[l][0] <= (py[l] >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
          cx[l][0] <= px[l];
          cy[l][0] <= py[l];
          cz[l][0] <= '0;
        end
      end
      for (int s = 0; s < N; s++) begin
        cs_sat[s+1] <= cs_sat[s];
        cs_neg[s+1] <= cs_neg[s];
      end
    end
  end

  // ---------------- CORDIC chain, three lanes side by side
  for (genvar s = 0; s < N; s++) begin : g_cordic
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      qte_cordic_cell #(.IDX(s)) u_cell (
        .clk   (clk),
        .en    (en),
        .x_in  (cx[l][s]),
        .y_in  (cy[l][s]),
        .z_in  (cz[l][s]),
        .x_out (cx[l][s+1]),
        .y_out (cy[l][s+1]),
        .z_out (cz[l][s+1])
      );
    end
  end

  // ---------------- round Q30 to Q13, clamp, output register
  logic signed [ZW-1:0] zr [LANES];
  logic signed [OW-1:0] rr [LANES];
  logic signed [OW-1:0] roll_c, pitch_c, yaw_c;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      zr[l] = (cz[l][N] + (ZW'(1) <<< 16)) >>> 17;
      rr[l] = zr[l][OW-1:0];
    end
    roll_c = rr[LROLL];
    if (roll_c > PI_Q13) roll_c = PI_Q13;
    if (roll_c < -PI_Q13) roll_c = -PI_Q13;
    yaw_c = rr[LYAW];
    if (yaw_c > PI_Q13) yaw_c = PI_Q13;
    if (yaw_c < -PI_Q13) yaw_c = -PI_Q13;
    pitch_c = rr[LPITCH];
    if (pitch_c > HALF_PI_Q13) pitch_c = HALF_PI_Q13;
    if (pitch_c < -HALF_PI_Q13) pitch_c = -HALF_PI_Q13;
    // |s| >= 1: pitch pinned to +-pi/2 by the sign of the term
    if (cs_sat[N]) pitch_c = cs_neg[N] ? -HALF_PI_Q13 : HALF_PI_Q13;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle  <= roll_c[AW-1:0];
      pitch_angle <= pitch_c[HW-1:0];
      yaw_angle   <= yaw_c[AW-1:0];
    end
  end

  // ---------------- checks
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pitch_angle <= 15'sd12868) && (pitch_angle >= -15'sd12868))
    else $error("pitch out of range");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (roll_angle <= 16'sd25736) && (roll_angle >= -16'sd25736))
    else $error("roll out of range");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (yaw_angle <= 16'sd25736) && (yaw_angle >= -16'sd25736))
    else $error("yaw out of range");

  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted beat lost at pipe entry");

endmodule
`default_nettype wire
